### sv/ecpa_pkg.sv
package ecpa_pkg;

    localparam int FIELD_W = 64;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A = 1'd1;

    typedef struct packed {
        logic [FIELD_W-1:0] first_x;
        logic [FIELD_W-1:0] first_y;
        logic [FIELD_W-1:0] second_x;
        logic [FIELD_W-1:0] second_y;
    } point_pair_t;

    typedef struct packed {
        logic [FIELD_W-1:0] sum_x;
        logic [FIELD_W-1:0] sum_y;
        logic               factor_found;
        logic [FIELD_W-1:0] factor_value;
    } point_sum_t;

endpackage

### sv/ecpa_mulmod.sv
module ecpa_mulmod #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic [WIDTH-1:0] modulus,
    output logic             done,
    output logic [WIDTH-1:0] product
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             phase_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH:0]   addend;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] acc_next;

    // doubling in phase 0, conditional add of a in phase 1
    always_comb
    begin
        addend = phase_reg ? {1'b0, a_reg} : {1'b0, acc_reg};
        sum = {1'b0, acc_reg} + addend;
        if (sum >= {1'b0, modulus})
        begin
            sum = sum - {1'b0, modulus};
        end
        acc_next = sum[WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                acc_reg   <= '0;
                a_reg     <= op_a;
                b_reg     <= op_b;
                cnt_reg   <= CNT_W'(WIDTH - 1);
                phase_reg <= 1'b0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!phase_reg)
                begin
                    acc_reg   <= acc_next;
                    phase_reg <= 1'b1;
                end
                else
                begin
                    if (b_reg[WIDTH-1])
                    begin
                        acc_reg <= acc_next;
                    end
                    b_reg     <= {b_reg[WIDTH-2:0], 1'b0};
                    phase_reg <= 1'b0;
                    if (cnt_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### sv/ec_point_add_mod_n.sv
// sequence: bit-serial reduction of the operands, then a shift-and-add modular multiply
// (one before the inverse on the doubling path, three once the inverse exists)
// and euclid steps with a shift-subtract quotient; a factor ends the request early
// throughput: one request at a time; the next is taken once the result is registered
// reset: modulus 3, coefficient a 0, no result pending
module ec_point_add_mod_n
    import ecpa_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    output logic                 point_stall,
    input  point_pair_t          point,
    output logic                 sum_valid,
    input  logic                 sum_stall,
    output point_sum_t           sum,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int LANES = 5;

    typedef enum logic [4:0] {
        S_IDLE, S_RED, S_BRANCH, S_DBL_MUL, S_DBL_2, S_DBL_3, S_DBL_A,
        S_EU_CHK, S_EU_ALIGN, S_EU_DIVA, S_EU_DIVB, S_EU_NEXT,
        S_MUL_S, S_MUL_SS, S_X3, S_U, S_MUL_Y, S_OUT
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] coeff_reg;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] src_reg [LANES];
    logic [WIDTH-1:0] rem_reg [LANES];
    logic [WIDTH-1:0] rem_next [LANES];
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] num_reg;
    logic [WIDTH-1:0] r0_reg;
    logic [WIDTH-1:0] r1_reg;
    logic [WIDTH-1:0] d_reg;
    logic [WIDTH-1:0] t0_reg;
    logic [WIDTH-1:0] t1_reg;
    logic [WIDTH-1:0] acc_reg;
    logic             qbit_reg;
    logic [WIDTH-1:0] s_reg;
    logic [WIDTH-1:0] x3_reg;
    logic             mul_start_reg;
    logic [WIDTH-1:0] mul_a_reg;
    logic [WIDTH-1:0] mul_b_reg;
    logic             mul_done;
    logic [WIDTH-1:0] mul_prod;
    point_sum_t       res_reg;
    point_sum_t       sum_reg;
    logic             sum_valid_reg;
    logic [WIDTH-1:0] m_eff;
    logic [WIDTH-1:0] d_dbl;
    logic [WIDTH:0]   lane_t [LANES];

    function automatic logic [WIDTH-1:0] add_m(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
        logic [WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] sub_m(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] r;
        r = a - b;
        if (a < b)
        begin
            r = r + m;
        end
        return r;
    endfunction

    assign m_eff = (modulus_reg == '0) ? WIDTH'(1) : modulus_reg;
    assign d_dbl = {d_reg[WIDTH-2:0], 1'b0};

    // one restoring-division bit per lane per cycle
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lane_t[i] = {rem_reg[i], src_reg[i][WIDTH-1]};
            if (lane_t[i] >= {1'b0, m_reg})
            begin
                lane_t[i] = lane_t[i] - {1'b0, m_reg};
            end
            rem_next[i] = lane_t[i][WIDTH-1:0];
        end
    end

    ecpa_mulmod #(
        .WIDTH(WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .modulus (m_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= WIDTH'(3);
            coeff_reg     <= '0;
            mul_start_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            if (sum_valid_reg && !sum_stall)
            begin
                sum_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MODULUS: modulus_reg <= cfg_data[WIDTH-1:0];
                    CFG_COEFF_A: coeff_reg   <= cfg_data[WIDTH-1:0];
                    default:     ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (point_valid)
                    begin
                        m_reg      <= m_eff;
                        src_reg[0] <= point.first_x[WIDTH-1:0];
                        src_reg[1] <= point.first_y[WIDTH-1:0];
                        src_reg[2] <= point.second_x[WIDTH-1:0];
                        src_reg[3] <= point.second_y[WIDTH-1:0];
                        src_reg[4] <= coeff_reg;
                        for (int i = 0; i < LANES; i++)
                        begin
                            rem_reg[i] <= '0;
                        end
                        cnt_reg    <= CNT_W'(WIDTH - 1);
                        state_reg  <= S_RED;
                    end
                end
                S_RED:
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        rem_reg[i] <= rem_next[i];
                        src_reg[i] <= {src_reg[i][WIDTH-2:0], 1'b0};
                    end
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_BRANCH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_BRANCH:
                begin
                    r0_reg <= m_reg;
                    t0_reg <= '0;
                    t1_reg <= (m_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
                    if (rem_reg[0] == rem_reg[2])
                    begin
                        mul_a_reg     <= rem_reg[0];
                        mul_b_reg     <= rem_reg[0];
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_DBL_MUL;
                    end
                    else
                    begin
                        num_reg   <= sub_m(rem_reg[3], rem_reg[1], m_reg);
                        r1_reg    <= sub_m(rem_reg[2], rem_reg[0], m_reg);
                        state_reg <= S_EU_CHK;
                    end
                end
                S_DBL_MUL:
                begin
                    if (mul_done)
                    begin
                        num_reg   <= mul_prod;
                        s_reg     <= mul_prod;
                        state_reg <= S_DBL_2;
                    end
                end
                S_DBL_2:
                begin
                    num_reg   <= add_m(num_reg, num_reg, m_reg);
                    state_reg <= S_DBL_3;
                end
                S_DBL_3:
                begin
                    num_reg   <= add_m(num_reg, s_reg, m_reg);
                    state_reg <= S_DBL_A;
                end
                S_DBL_A:
                begin
                    num_reg   <= add_m(num_reg, rem_reg[4], m_reg);
                    r1_reg    <= add_m(rem_reg[1], rem_reg[1], m_reg);
                    state_reg <= S_EU_CHK;
                end
                S_EU_CHK:
                begin
                    if (r1_reg == '0)
                    begin
                        if (r0_reg != WIDTH'(1))
                        begin
                            res_reg.sum_x        <= '0;
                            res_reg.sum_y        <= '0;
                            res_reg.factor_found <= 1'b1;
                            res_reg.factor_value <= FIELD_W'(r0_reg);
                            state_reg            <= S_OUT;
                        end
                        else
                        begin
                            mul_a_reg     <= num_reg;
                            mul_b_reg     <= t0_reg;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_MUL_S;
                        end
                    end
                    else
                    begin
                        d_reg     <= r1_reg;
                        cnt_reg   <= '0;
                        state_reg <= S_EU_ALIGN;
                    end
                end
                S_EU_ALIGN:
                begin
                    if (!d_reg[WIDTH-1] && (d_dbl <= r0_reg))
                    begin
                        d_reg   <= d_dbl;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        acc_reg   <= '0;
                        state_reg <= S_EU_DIVA;
                    end
                end
                S_EU_DIVA:
                begin
                    qbit_reg <= (r0_reg >= d_reg);
                    if (r0_reg >= d_reg)
                    begin
                        r0_reg <= r0_reg - d_reg;
                    end
                    acc_reg   <= add_m(acc_reg, acc_reg, m_reg);
                    state_reg <= S_EU_DIVB;
                end
                S_EU_DIVB:
                begin
                    if (qbit_reg)
                    begin
                        acc_reg <= add_m(acc_reg, t1_reg, m_reg);
                    end
                    d_reg <= {1'b0, d_reg[WIDTH-1:1]};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_EU_NEXT;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= S_EU_DIVA;
                    end
                end
                S_EU_NEXT:
                begin
                    r0_reg    <= r1_reg;
                    r1_reg    <= r0_reg;
                    t0_reg    <= t1_reg;
                    t1_reg    <= sub_m(t0_reg, acc_reg, m_reg);
                    state_reg <= S_EU_CHK;
                end
                S_MUL_S:
                begin
                    if (mul_done)
                    begin
                        s_reg         <= mul_prod;
                        mul_a_reg     <= mul_prod;
                        mul_b_reg     <= mul_prod;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_SS;
                    end
                end
                S_MUL_SS:
                begin
                    if (mul_done)
                    begin
                        x3_reg    <= sub_m(mul_prod, rem_reg[0], m_reg);
                        state_reg <= S_X3;
                    end
                end
                S_X3:
                begin
                    x3_reg    <= sub_m(x3_reg, rem_reg[2], m_reg);
                    state_reg <= S_U;
                end
                S_U:
                begin
                    mul_a_reg     <= s_reg;
                    mul_b_reg     <= sub_m(rem_reg[0], x3_reg, m_reg);
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_MUL_Y;
                end
                S_MUL_Y:
                begin
                    if (mul_done)
                    begin
                        res_reg.sum_x        <= FIELD_W'(x3_reg);
                        res_reg.sum_y        <= FIELD_W'(sub_m(mul_prod, rem_reg[1], m_reg));
                        res_reg.factor_found <= 1'b0;
                        res_reg.factor_value <= '0;
                        state_reg            <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!sum_valid_reg || !sum_stall)
                    begin
                        sum_reg       <= res_reg;
                        sum_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign point_stall = (state_reg != S_IDLE);
    assign sum_valid   = sum_valid_reg;
    assign sum         = sum_reg;
    assign cfg_ready   = 1'b1;

`ifndef SYNTHESIS
    a_factor_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid && sum.factor_found |-> (sum.sum_x == '0) && (sum.sum_y == '0))
        else $error("factor result carries a point");

    a_point_no_factor: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid && !sum.factor_found |-> (sum.factor_value == '0))
        else $error("point result carries a factor value");

    a_point_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid && !sum.factor_found |->
        (sum.sum_x[WIDTH-1:0] < m_reg) && (sum.sum_y[WIDTH-1:0] < m_reg))
        else $error("result coordinate not reduced");

    a_euclid_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EU_NEXT |-> (r0_reg < r1_reg))
        else $error("euclid remainder not below divisor");
`endif

endmodule

### bench/ecpa_sum_checker.sv
`timescale 1ns / 1ps

module ecpa_sum_checker
    import ecpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    input  logic                 point_stall,
    input  point_pair_t          point,
    input  logic                 sum_valid,
    input  logic                 sum_stall,
    input  point_sum_t           sum,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   sums_pending
);

    logic [63:0] modulus_copy;
    logic [63:0] coeff_a_copy;
    point_sum_t  sums_due[$];

    function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] sub_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        return (a >= b) ? a - b : a + (m - b);
    endfunction

    function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) % {64'd0, m};
        return p[63:0];
    endfunction

    function automatic point_sum_t predict_sum(point_pair_t p, logic [63:0] n,
                                               logic [63:0] ca_raw);
        logic [63:0] m, x1, y1, x2, y2, ca, num, den;
        logic [63:0] r0, r1, r2, t0, t1, t2, q, slope, x3, y3;
        point_sum_t  r;
        m = (n == 0) ? 64'd1 : n;
        x1 = p.first_x % m;
        y1 = p.first_y % m;
        x2 = p.second_x % m;
        y2 = p.second_y % m;
        ca = ca_raw % m;
        if (x1 == x2)
        begin
            num = mul_mod(x1, x1, m);
            num = add_mod(add_mod(num, num, m), num, m);
            num = add_mod(num, ca, m);
            den = add_mod(y1, y1, m);
        end
        else
        begin
            num = sub_mod(y2, y1, m);
            den = sub_mod(x2, x1, m);
        end
        r0 = m;
        r1 = den;
        t0 = 0;
        t1 = 64'd1 % m;
        while (r1 != 0)
        begin
            q = r0 / r1;
            r2 = r0 % r1;
            t2 = sub_mod(t0, mul_mod(q % m, t1, m), m);
            r0 = r1;
            r1 = r2;
            t0 = t1;
            t1 = t2;
        end
        r = '0;
        if (r0 != 1)
        begin
            r.factor_found = 1'b1;
            r.factor_value = r0;
        end
        else
        begin
            slope = mul_mod(num, t0, m);
            x3 = sub_mod(sub_mod(mul_mod(slope, slope, m), x1, m), x2, m);
            y3 = sub_mod(mul_mod(slope, sub_mod(x1, x3, m), m), y1, m);
            r.sum_x = x3;
            r.sum_y = y3;
        end
        return r;
    endfunction

    assign sums_pending = sums_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_copy <= 64'd3;
            coeff_a_copy <= 64'd0;
            fail_count <= 0;
        end
        else
        begin
            int errs;
            errs = 0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MODULUS)
                begin
                    modulus_copy <= cfg_data;
                end
                else if (cfg_index == CFG_COEFF_A)
                begin
                    coeff_a_copy <= cfg_data;
                end
            end
            if (sum_valid && !sum_stall)
            begin
                if (sums_due.size() == 0)
                begin
                    $error("unexpected sum %h", sum);
                    errs++;
                end
                else
                begin
                    point_sum_t e;
                    e = sums_due.pop_front();
                    if (sum.sum_x !== e.sum_x)
                    begin
                        $error("sum_x expected %h actual %h", e.sum_x, sum.sum_x);
                        errs++;
                    end
                    if (sum.sum_y !== e.sum_y)
                    begin
                        $error("sum_y expected %h actual %h", e.sum_y, sum.sum_y);
                        errs++;
                    end
                    if (sum.factor_found !== e.factor_found)
                    begin
                        $error("factor_found expected %b actual %b",
                               e.factor_found, sum.factor_found);
                        errs++;
                    end
                    if (sum.factor_value !== e.factor_value)
                    begin
                        $error("factor_value expected %h actual %h",
                               e.factor_value, sum.factor_value);
                        errs++;
                    end
                end
            end
            if (point_valid && !point_stall)
            begin
                sums_due.push_back(predict_sum(point, modulus_copy, coeff_a_copy));
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

### bench/tb_ec_point_add_mod_n.sv
`timescale 1ns / 1ps

module tb_ec_point_add_mod_n;
    import ecpa_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 point_valid;
    logic                 point_stall;
    point_pair_t          point;
    logic                 sum_valid;
    logic                 sum_stall = 1'b0;
    point_sum_t           sum;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;
    int                   fail_count;
    int                   sums_pending;

    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_left = 0;
    logic hold_go = 1'b0;
    logic hold_used = 1'b0;

    ec_point_add_mod_n dut (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_stall(point_stall), .point(point),
        .sum_valid(sum_valid), .sum_stall(sum_stall), .sum(sum),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ecpa_sum_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_stall(point_stall), .point(point),
        .sum_valid(sum_valid), .sum_stall(sum_stall), .sum(sum),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .sums_pending(sums_pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // receiver stall, with a single long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            sum_stall <= 1'b1;
        end
        else if (hold_go && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= 3000;
            sum_stall <= 1'b1;
        end
        else
        begin
            sum_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] below(logic [63:0] m);
        return (m == 0) ? 64'd0 : rand64() % m;
    endfunction

    task automatic send_request(point_pair_t p);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_valid <= 1'b1;
        point <= p;
        @(posedge clk);
        while (point_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        point_valid <= 1'b0;
        @(posedge clk);
        while (sums_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic run_directed(logic [63:0] m);
        logic [63:0] a, b;
        a = below(m);
        b = below(m);
        send_request('{64'd0, 64'd0, 64'd0, 64'd0});
        send_request('{'1, '1, '1, '1});
        send_request('{'1, 64'd0, 64'd0, '1});
        send_request('{a, b, a, b});
        send_request('{a, b, a, below(m)});
        send_request('{a, 64'd0, a, b});
        send_request('{a, b, b, a});
        send_request('{a, b, a + m, b});
        send_request('{m - 1, m - 1, 64'd0, 64'd1});
        send_request('{64'd1, 64'd2, 64'd1, 64'd2});
    endtask

    task automatic run_random(logic [63:0] m, int count);
        point_pair_t p;
        int kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(99);
            p = '{below(m), below(m), below(m), below(m)};
            if (kind < 15)
            begin
                p.second_x = p.first_x;
            end
            else if (kind < 25)
            begin
                p.second_x = p.first_x;
                p.second_y = p.first_y;
            end
            else if (kind < 40)
            begin
                p = '{rand64(), rand64(), rand64(), rand64()};
            end
            send_request(p);
        end
    endtask

    logic [63:0] moduli[10];
    logic [63:0] coeffs[10];

    initial
    begin
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MODULUS;
        cfg_data = '0;
        send_idle_pct = 26;
        recv_idle_pct = 74;
        moduli = '{64'd3, 64'd15, 64'd2021, 64'd0, '1, 64'h1FFF_FFFF_FFFF_FFFF,
                   64'd1000, rand64() | 64'd1, 64'd1, 64'h8000_0000_0000_0001};
        coeffs = '{64'd0, 64'd7, rand64(), 64'd5, '1, rand64(),
                   64'd999, rand64(), 64'd0, '1};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                write_reg(CFG_MODULUS, moduli[ph]);
                write_reg(CFG_COEFF_A, coeffs[ph]);
            end
            if (ph == 4)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 26;
            end
            else if (ph == 7)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 2)
            begin
                hold_go <= 1'b1;
            end
            if (ph < 3)
            begin
                run_directed(moduli[ph] == 0 ? 64'd1 : moduli[ph]);
            end
            run_random(moduli[ph] == 0 ? 64'd1 : moduli[ph], 80);
        end
        drain();
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #(12 * 20_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
